FILE: rtl/test_pattern_bit_slicer_assert.svh
// Assertion helpers shared by the slicer RTL.
`ifndef TEST_PATTERN_BIT_SLICER_ASSERT_SVH
`define TEST_PATTERN_BIT_SLICER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TPBS_ASSERT_IMPLIES(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define TPBS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/tpbs_pkg.sv
package tpbs_pkg;

   localparam int MAX_LINES_DEFAULT = 32;
   localparam int LANE_BITS_DEFAULT = 64;

   localparam int PATTERN_WIDTH   = 32;
   localparam int SLICE_WIDTH     = 64;
   localparam int INDEX_WIDTH     = 5;
   localparam int TOTAL_WIDTH     = 7;
   localparam int LINES_WIDTH     = 7;
   localparam int LINE_CFG_WIDTH  = 6;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = LINE_CFG_WIDTH;
   localparam int REQ_TDATA_WIDTH = 32;
   localparam int RSP_TDATA_WIDTH = 80;
   localparam int RSP_PAD_WIDTH   =
      RSP_TDATA_WIDTH - SLICE_WIDTH - INDEX_WIDTH - TOTAL_WIDTH;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LINE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYMMETRY   = 1'b1;

   localparam logic [LINE_CFG_WIDTH-1:0] LINE_COUNT_RESET = 6'd32;

   // Hand-off of a finished buffer from the packer to the emitter.
   typedef struct packed {
      logic                   valid;
      logic [TOTAL_WIDTH-1:0] total;
      logic [LINES_WIDTH-1:0] lines;
   } flush_req_type;

endpackage

FILE: rtl/tpbs_pack.sv
module tpbs_pack #(
   parameter int MAX_LINES = tpbs_pkg::MAX_LINES_DEFAULT,
   parameter int LANE_BITS = tpbs_pkg::LANE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tpbs_pkg::LINES_WIDTH-1:0]    lines,
   input  logic                                symmetry_on,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [tpbs_pkg::PATTERN_WIDTH-1:0]  in_pattern,
   input  logic                                in_last,
   input  logic                                emit_ready,
   output tpbs_pkg::flush_req_type             flush_req,
   output logic [LANE_BITS-1:0]                flush_words [MAX_LINES]
);

   localparam int CW      = $clog2(LANE_BITS + 1);
   localparam int LINES_W = tpbs_pkg::LINES_WIDTH;

   logic                               s1_valid_ff, s1_valid_in;
   logic [tpbs_pkg::PATTERN_WIDTH-1:0] s1_pattern_ff;
   logic                               s1_last_ff;
   logic [LANE_BITS-1:0]               buf_ff [MAX_LINES];
   logic [LANE_BITS-1:0]               buf_in [MAX_LINES];
   logic [LANE_BITS-1:0]               shifted [MAX_LINES];
   logic [CW-1:0]                      cnt_ff, cnt_in, cnt_keep, cnt_now;

   logic [63:0] w64, mask, zeros, rev, mirror;
   logic        sorted, mirror_smaller, keep, full, flush_need, advance;

   // Pattern tests: sorted means the zeros of the used bits sit at the bottom.
   always_comb begin
      w64    = 64'(s1_pattern_ff);
      mask   = (lines >= 7'd64) ? '1 : ((64'd1 << lines) - 64'd1);
      zeros  = ~w64 & mask;
      sorted = ((zeros & (zeros + 64'd1)) == 64'd0);
      for (int j = 0; j < 64; j++) begin
         rev[j] = ~w64[63-j];
      end
      mirror         = rev >> (7'd64 - lines);
      mirror_smaller = (w64 > mirror);
      keep           = !(symmetry_on && mirror_smaller) && !sorted;
   end

   // Every line shifts on a kept pattern; lines at or above the count take a zero.
   always_comb begin
      for (int b = 0; b < MAX_LINES; b++) begin
         shifted[b] = {buf_ff[b][LANE_BITS-2:0],
                       (LINES_W'(b) < lines) ? w64[b] : 1'b0};
      end
   end

   always_comb begin
      cnt_keep   = cnt_ff + CW'(1);
      cnt_now    = keep ? cnt_keep : cnt_ff;
      full       = keep && (cnt_keep == CW'(LANE_BITS));
      flush_need = s1_valid_ff && (full || (s1_last_ff && (cnt_now != '0)));
      advance    = !flush_need || emit_ready;
      in_ready   = !s1_valid_ff || advance;

      flush_req.valid = flush_need;
      flush_req.total = tpbs_pkg::TOTAL_WIDTH'(cnt_now);
      flush_req.lines = lines;
      for (int b = 0; b < MAX_LINES; b++) begin
         flush_words[b] = keep ? shifted[b] : buf_ff[b];
      end

      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (s1_valid_ff && advance) begin
         if (flush_need) begin
            for (int b = 0; b < MAX_LINES; b++) begin
               buf_in[b] = '0;
            end
            cnt_in = '0;
         end else if (keep) begin
            buf_in = shifted;
            cnt_in = cnt_keep;
         end
      end

      if (in_valid && in_ready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         for (int b = 0; b < MAX_LINES; b++) begin
            buf_ff[b] <= '0;
         end
      end else begin
         s1_valid_ff <= s1_valid_in;
         cnt_ff      <= cnt_in;
         buf_ff      <= buf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_pattern_ff <= in_pattern;
         s1_last_ff    <= in_last;
      end
   end

endmodule

FILE: rtl/tpbs_emit.sv
module tpbs_emit #(
   parameter int MAX_LINES = tpbs_pkg::MAX_LINES_DEFAULT,
   parameter int LANE_BITS = tpbs_pkg::LANE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tpbs_pkg::flush_req_type               flush_req,
   input  logic [LANE_BITS-1:0]                  flush_words [MAX_LINES],
   output logic                                  emit_ready,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output logic [tpbs_pkg::RSP_TDATA_WIDTH-1:0]  out_data,
   output logic                                  out_last
);

   localparam int IW = $clog2(MAX_LINES);

   logic [LANE_BITS-1:0]               bank_ff [MAX_LINES];
   logic [tpbs_pkg::TOTAL_WIDTH-1:0]   total_ff;
   logic [tpbs_pkg::LINES_WIDTH-1:0]   lines_ff;
   logic [IW-1:0]                      idx_ff;
   logic                               busy_ff;
   logic                               valid_ff;
   logic [tpbs_pkg::RSP_TDATA_WIDTH-1:0] data_ff;
   logic                               last_ff;

   logic take, load, last_word;

   always_comb begin
      emit_ready = !busy_ff;
      take       = flush_req.valid && !busy_ff;
      load       = busy_ff && (!valid_ff || out_ready);
      last_word  = (tpbs_pkg::LINES_WIDTH'(idx_ff) == (lines_ff - 7'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         if (take) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end else if (load) begin
            busy_ff <= !last_word;
            idx_ff  <= idx_ff + IW'(1);
         end
         if (load) begin
            valid_ff <= 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         bank_ff  <= flush_words;
         total_ff <= flush_req.total;
         lines_ff <= flush_req.lines;
      end
      if (load) begin
         data_ff <= {{tpbs_pkg::RSP_PAD_WIDTH{1'b0}}, total_ff,
                     tpbs_pkg::INDEX_WIDTH'(idx_ff),
                     tpbs_pkg::SLICE_WIDTH'(bank_ff[idx_ff])};
         last_ff <= last_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_last  = last_ff;

endmodule

FILE: rtl/test_pattern_bit_slicer.sv
// Channel   | Direction | Transfer carries
// ----------+-----------+------------------------------------------------------------
// req_      | in        | tdata: pattern[31:0]; tlast: end_of_list
// rsp_      | out       | tdata: slice_word, line_index, pattern_total; tlast: run_last
// csr_      | in        | write enable, register index, write data
//
// One pattern is taken per cycle while req_tready is high; it is held in the input register
// where the sorted and mirror tests and the per-line shift are done.
// A flush copies the whole line buffer into an emit bank in that same cycle, and the bank
// then sends one word per cycle while rsp_tready is high, so a flush of n lines gives n result words.
// If a second flush comes due while the bank is still sending, req_tready drops until
// the bank is empty. Reset is synchronous and clears the buffer, counts and valids;
// rsp_tready low simply holds the result register and, in turn, the bank.
`include "test_pattern_bit_slicer_assert.svh"

module test_pattern_bit_slicer #(
   parameter int MAX_LINES = tpbs_pkg::MAX_LINES_DEFAULT,
   parameter int LANE_BITS = tpbs_pkg::LANE_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // Input transfer.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [tpbs_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,  // [31:0] pattern
   input  logic                                  req_tlast,  // end_of_list
   // Result transfer.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [63:0] slice_word, [68:64] line_index, [75:69] pattern_total, rest zero
   output logic [tpbs_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   output logic                                  rsp_tlast,  // run_last
   // Configuration writes.
   input  logic                                  csr_we,
   input  logic [tpbs_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [tpbs_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);

   logic [tpbs_pkg::LINE_CFG_WIDTH-1:0] line_count_ff;
   logic                                symmetry_ff;
   logic [tpbs_pkg::LINES_WIDTH-1:0]    line_raw;
   logic [tpbs_pkg::LINES_WIDTH-1:0]    lines;

   tpbs_pkg::flush_req_type flush_req;
   logic [LANE_BITS-1:0]    flush_words [MAX_LINES];
   logic                    emit_ready;

   // Configuration registers. The index field has no spare codes.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= tpbs_pkg::LINE_COUNT_RESET;
         symmetry_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            tpbs_pkg::CSR_LINE_COUNT: line_count_ff <= csr_wdata;
            tpbs_pkg::CSR_SYMMETRY:   symmetry_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The line count in use is the register clamped to two up to the line capacity.
   always_comb begin
      line_raw = tpbs_pkg::LINES_WIDTH'(line_count_ff);
      if (line_raw < 7'd2) begin
         lines = 7'd2;
      end else if (line_raw > tpbs_pkg::LINES_WIDTH'(MAX_LINES)) begin
         lines = tpbs_pkg::LINES_WIDTH'(MAX_LINES);
      end else begin
         lines = line_raw;
      end
   end

   tpbs_pack #(
      .MAX_LINES (MAX_LINES),
      .LANE_BITS (LANE_BITS)
   ) u_pack (
      .clock       (clock),
      .reset       (reset),
      .lines       (lines),
      .symmetry_on (symmetry_ff),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_pattern  (req_tdata[tpbs_pkg::PATTERN_WIDTH-1:0]),
      .in_last     (req_tlast),
      .emit_ready  (emit_ready),
      .flush_req   (flush_req),
      .flush_words (flush_words)
   );

   tpbs_emit #(
      .MAX_LINES (MAX_LINES),
      .LANE_BITS (LANE_BITS)
   ) u_emit (
      .clock       (clock),
      .reset       (reset),
      .flush_req   (flush_req),
      .flush_words (flush_words),
      .emit_ready  (emit_ready),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

   // Words of one flush follow each other without gaps while the sink takes them.
   `TPBS_ASSERT_NEXT(a_run_no_gap, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "gap inside a run of slice words")
   // Every emitted word carries at least one pattern.
   `TPBS_ASSERT_IMPLIES(a_total_nonzero, rsp_tvalid, rsp_tdata[75:69] != 7'd0, "slice word with zero patterns")
   // Input back-pressure only ever comes from a busy emit bank.
   `TPBS_ASSERT_IMPLIES(a_stall_cause, !req_tready, !emit_ready, "input stalled while emit bank idle")

endmodule
